[rtl/fbsc_pkg.sv]
`timescale 1ns / 1ps
// fbsc_pkg: shared types and constants of the frustum box/sphere cull block.
// No dependencies.

package fbsc_pkg;

	localparam int MAX_PLANES    = 6;
	localparam int FULL_FRUSTUM  = 6;
	localparam int COORD_W       = 32;
	localparam int PLANE_W       = 4 * COORD_W;
	localparam int ACC_W         = 66;
	localparam int FRAC_W        = 16;
	localparam logic [2:0] PLANES_RESET = 3'd6;

	typedef logic signed [COORD_W-1:0] q16_t;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_BOX    = 2'd1,
		KIND_SPHERE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic REG_PLANES = 1'b0;

	// control from the sequencer to the shared dot unit
	typedef struct packed {
		logic init;
		logic mul_en;
		logic add_lo;
		logic add_hi;
	} dot_ctl_t;

	// sign flags of the two accumulators
	typedef struct packed {
		logic lo_pos;
		logic hi_neg;
	} dot_flags_t;

endpackage

[rtl/fbsc_ram.sv]
`timescale 1ns / 1ps
// fbsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module fbsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/fbsc_dot.sv]
`timescale 1ns / 1ps
// fbsc_dot: shared multiply-accumulate unit, one 32x32 product per cycle into
// two wide accumulators. Depends on fbsc_pkg.

module fbsc_dot (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbsc_pkg::dot_ctl_t    ctl,
	input  fbsc_pkg::q16_t        opa,
	input  fbsc_pkg::q16_t        opb,
	input  fbsc_pkg::q16_t        offset,
	input  fbsc_pkg::q16_t        radius,
	output fbsc_pkg::dot_flags_t  flags
);

	localparam int SUM_W = fbsc_pkg::COORD_W + 1;
	localparam int EXT_W = fbsc_pkg::ACC_W - SUM_W - fbsc_pkg::FRAC_W;

	logic signed [2*fbsc_pkg::COORD_W-1:0] prod_s1;
	logic                                  add_lo_s1;
	logic                                  add_hi_s1;
	logic signed [fbsc_pkg::ACC_W-1:0]     acc_lo_q;
	logic signed [fbsc_pkg::ACC_W-1:0]     acc_hi_q;
	logic signed [SUM_W-1:0]               sum_hi;
	logic signed [SUM_W-1:0]               sum_lo;
	logic signed [fbsc_pkg::ACC_W-1:0]     init_hi;
	logic signed [fbsc_pkg::ACC_W-1:0]     init_lo;

	// offset +/- radius, scaled to Q32.32
	assign sum_hi  = SUM_W'(offset) + SUM_W'(radius);
	assign sum_lo  = SUM_W'(offset) - SUM_W'(radius);
	assign init_hi = {{EXT_W{sum_hi[SUM_W-1]}}, sum_hi, {fbsc_pkg::FRAC_W{1'b0}}};
	assign init_lo = {{EXT_W{sum_lo[SUM_W-1]}}, sum_lo, {fbsc_pkg::FRAC_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_lo_s1 <= 1'b0;
			add_hi_s1 <= 1'b0;
		end else begin
			add_lo_s1 <= ctl.mul_en & ctl.add_lo;
			add_hi_s1 <= ctl.mul_en & ctl.add_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= opa * opb;
		end
		if (ctl.init) begin
			acc_lo_q <= init_lo;
			acc_hi_q <= init_hi;
		end else begin
			if (add_lo_s1) begin
				acc_lo_q <= acc_lo_q + fbsc_pkg::ACC_W'(prod_s1);
			end
			if (add_hi_s1) begin
				acc_hi_q <= acc_hi_q + fbsc_pkg::ACC_W'(prod_s1);
			end
		end
	end

	assign flags.lo_pos = !acc_lo_q[fbsc_pkg::ACC_W-1] && (|acc_lo_q);
	assign flags.hi_neg = acc_hi_q[fbsc_pkg::ACC_W-1];

endmodule

[rtl/frustum_box_sphere_cull.sv]
`timescale 1ns / 1ps
// frustum_box_sphere_cull: top level with sequencer, item and result registers,
// APB register. Depends on fbsc_pkg, fbsc_ram, fbsc_dot.
//
// Usage:
//   Input stream s_*: s_tuser carries the item kind (load plane, test box,
//   test sphere). A load writes plane slot from the normal (ax, ay, az) and
//   offset (scalar); a test checks the box (a = min, b = max corner) or the
//   sphere (a = centre, scalar = radius) against the loaded planes.
//   Output stream m_*: one transfer per input item, visible in m_tdata[0],
//   was_test in m_tuser[0] (0 for loads and unused kinds).
//   APB register 0 (address 0): planes_in_use, 3 bits, reset 6. From one to
//   five, plane 0 acts as a straddle plane.
//   One item at a time: s_tready is high only while the sequencer is idle.
//   A load passes through states LOAD and DONE; a test visits each plane in
//   turn through table read (FETCH), the single shared multiplier (MUL, one
//   product per cycle: 3 per sphere plane, 6 per box plane), DRAIN and CHECK,
//   then goes to DONE. Visiting stops at the first rejecting plane.
//   The result register frees the input side once the result is parked; if
//   m_tready stays low, the next item finishes and waits until the slot empties.
//   Reset clears control and sets planes_in_use to 6; the plane table is
//   not cleared and must be loaded before a test uses it.

module frustum_box_sphere_cull #(
	parameter int MAX_PLANES = fbsc_pkg::MAX_PLANES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [231:0] s_tdata,   // slot[2:0], ax, ay, az, bx, by, bz, scalar, pad
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // visible[0], pad
	output logic [0:0]   m_tuser,   // was_test[0]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int PA_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int CNT_W = $clog2(MAX_PLANES + 1);
	localparam int CW    = fbsc_pkg::COORD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_FETCH,
		ST_MUL,
		ST_DRAIN,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [2:0]           planes_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	logic [2:0]           step_q;
	logic                 straddle_q;
	logic                 vis_q;
	logic                 out_valid_q;
	logic                 out_vis_q;
	logic                 out_test_q;

	fbsc_pkg::kind_t      kind_q;
	logic [2:0]           slot_q;
	fbsc_pkg::q16_t       a_q [3];
	fbsc_pkg::q16_t       b_q [3];
	fbsc_pkg::q16_t       s_q;

	logic                 in_fire;
	logic                 cfg_wr;
	logic                 done_fire;
	logic [3:0]           piu_ext;
	logic [3:0]           cnt_next;
	logic                 is_sphere;
	logic                 is_test;
	logic                 last_step;
	logic [1:0]           axis;
	logic                 half;
	logic                 slot_ok;
	logic                 reject;
	logic [CNT_W-1:0]     k_next;

	logic [fbsc_pkg::PLANE_W-1:0] plane_wdata;
	logic [fbsc_pkg::PLANE_W-1:0] plane_rdata;
	fbsc_pkg::q16_t       n_sel;
	fbsc_pkg::q16_t       mn_sel;
	fbsc_pkg::q16_t       mx_sel;
	fbsc_pkg::q16_t       small_v;
	fbsc_pkg::q16_t       big_v;
	fbsc_pkg::q16_t       opb;
	fbsc_pkg::q16_t       radius;
	fbsc_pkg::dot_ctl_t   ctl;
	fbsc_pkg::dot_flags_t flags;

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == fbsc_pkg::REG_PLANES) ? {29'd0, planes_q} : 32'd0;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign piu_ext   = {1'b0, planes_q};
	assign cnt_next  = (piu_ext > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : piu_ext;

	assign is_sphere = (kind_q == fbsc_pkg::KIND_SPHERE);
	assign is_test   = (kind_q == fbsc_pkg::KIND_BOX) || is_sphere;
	assign last_step = is_sphere ? (step_q == 3'd2) : (step_q == 3'd5);
	assign axis      = is_sphere ? step_q[1:0] : step_q[2:1];
	assign half      = step_q[0];
	assign slot_ok   = ({1'b0, slot_q} < 4'(MAX_PLANES));
	assign k_next    = CNT_W'(k_q + 1'b1);
	assign radius    = is_sphere ? s_q : '0;

	// plane word: {offset, nz, ny, nx}
	assign plane_wdata = {s_q, a_q[2], a_q[1], a_q[0]};

	always_comb begin
		case (axis)
			2'd0:    begin n_sel = plane_rdata[CW-1:0];    mn_sel = a_q[0]; mx_sel = b_q[0]; end
			2'd1:    begin n_sel = plane_rdata[2*CW-1:CW]; mn_sel = a_q[1]; mx_sel = b_q[1]; end
			2'd2:    begin n_sel = plane_rdata[3*CW-1:2*CW]; mn_sel = a_q[2]; mx_sel = b_q[2]; end
			default: begin n_sel = '0; mn_sel = '0; mx_sel = '0; end
		endcase
	end

	// a nonnegative normal takes its extreme distances at the extreme coordinates,
	// a negative one at the opposite ones
	always_comb begin
		small_v = (mn_sel <= mx_sel) ? mn_sel : mx_sel;
		big_v   = (mn_sel <= mx_sel) ? mx_sel : mn_sel;
		if (is_sphere) begin
			opb = mn_sel;
		end else if (half ^ n_sel[CW-1]) begin
			opb = big_v;
		end else begin
			opb = small_v;
		end
	end

	assign ctl.init   = (state_q == ST_MUL) && (step_q == 3'd0);
	assign ctl.mul_en = (state_q == ST_MUL);
	assign ctl.add_lo = is_sphere || !half;
	assign ctl.add_hi = is_sphere || half;

	assign reject = (straddle_q && (k_q == '0)) ? (flags.lo_pos || flags.hi_neg)
	                                           : flags.hi_neg;

	fbsc_ram #(
		.WIDTH(fbsc_pkg::PLANE_W),
		.DEPTH(MAX_PLANES)
	) u_planes (
		.clk  (clk),
		.we   ((state_q == ST_LOAD) && slot_ok),
		.waddr(slot_q[PA_W-1:0]),
		.wdata(plane_wdata),
		.re   (state_q == ST_FETCH),
		.raddr(k_q[PA_W-1:0]),
		.rdata(plane_rdata)
	);

	fbsc_dot u_dot (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.opa   (n_sel),
		.opb   (opb),
		.offset(plane_rdata[4*CW-1:3*CW]),
		.radius(radius),
		.flags (flags)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= fbsc_pkg::kind_t'(s_tuser);
			slot_q <= s_tdata[2:0];
			a_q[0] <= s_tdata[34:3];
			a_q[1] <= s_tdata[66:35];
			a_q[2] <= s_tdata[98:67];
			b_q[0] <= s_tdata[130:99];
			b_q[1] <= s_tdata[162:131];
			b_q[2] <= s_tdata[194:163];
			s_q    <= s_tdata[226:195];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			planes_q    <= fbsc_pkg::PLANES_RESET;
			count_q     <= '0;
			k_q         <= '0;
			step_q      <= '0;
			straddle_q  <= 1'b0;
			vis_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_vis_q   <= 1'b0;
			out_test_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == fbsc_pkg::REG_PLANES)) begin
				planes_q <= pwdata[2:0];
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
				out_vis_q   <= vis_q && is_test;
				out_test_q  <= is_test;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						count_q    <= CNT_W'(cnt_next);
						straddle_q <= (cnt_next != 4'd0) &&
						              (cnt_next < 4'(fbsc_pkg::FULL_FRUSTUM));
						k_q        <= '0;
						step_q     <= '0;
						vis_q      <= 1'b1;
						if (s_tuser == fbsc_pkg::KIND_LOAD) begin
							state_q <= ST_LOAD;
						end else if (s_tuser == fbsc_pkg::KIND_NONE || cnt_next == 4'd0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DONE;
				end
				ST_FETCH: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (reject) begin
						vis_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (k_next == count_q) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_next;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_vis_q};
	assign m_tuser  = out_test_q;

`ifndef SYNTHESIS
	a_load_not_visible: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tdata[0])
		else $error("load result marked visible");

	a_plane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_MUL || state_q == ST_DRAIN ||
		 state_q == ST_CHECK) |-> (k_q < count_q))
		else $error("plane index beyond planes in use");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("second item taken while busy");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q)
		else $error("pending result dropped");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for frustum_box_sphere_cull (plane loads, box and sphere tests).
// Depends on fbsc_pkg and the frustum_box_sphere_cull RTL; scoreboard predicts in Q32.32.

module tb;

	localparam fbsc_pkg::q16_t ONE = 32'sh0001_0000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		fbsc_pkg::kind_t kind;
		logic [2:0]      slot;
		fbsc_pkg::q16_t  ax, ay, az, bx, by, bz, scalar;
	} cull_item_t;

	typedef struct {
		logic visible;
		logic was_test;
	} cull_answer_t;

	typedef logic signed [79:0] wide_t;

	class cull_scoreboard;
		fbsc_pkg::q16_t nx[fbsc_pkg::MAX_PLANES];
		fbsc_pkg::q16_t ny[fbsc_pkg::MAX_PLANES];
		fbsc_pkg::q16_t nz[fbsc_pkg::MAX_PLANES];
		fbsc_pkg::q16_t off[fbsc_pkg::MAX_PLANES];
		logic [2:0]     plane_count;
		cull_answer_t   pending_answers[$];
		int             mismatches;
		int             tests;
		int             visibles;

		function new();
			plane_count = fbsc_pkg::PLANES_RESET;
			mismatches = 0;
			tests = 0;
			visibles = 0;
			foreach (nx[i]) begin
				nx[i] = '0;
				ny[i] = '0;
				nz[i] = '0;
				off[i] = '0;
			end
		endfunction

		function wide_t widen(fbsc_pkg::q16_t v);
			wide_t w;
			w = v;
			return w;
		endfunction

		// min and max distance over the eight corners
		function void box_span(int k, cull_item_t it, output wide_t lo, output wide_t hi);
			wide_t p, q;
			lo = widen(off[k]) <<< fbsc_pkg::FRAC_W;
			hi = lo;
			p = widen(nx[k]) * widen(it.ax);
			q = widen(nx[k]) * widen(it.bx);
			lo += (p < q) ? p : q;
			hi += (p < q) ? q : p;
			p = widen(ny[k]) * widen(it.ay);
			q = widen(ny[k]) * widen(it.by);
			lo += (p < q) ? p : q;
			hi += (p < q) ? q : p;
			p = widen(nz[k]) * widen(it.az);
			q = widen(nz[k]) * widen(it.bz);
			lo += (p < q) ? p : q;
			hi += (p < q) ? q : p;
		endfunction

		function wide_t centre_distance(int k, cull_item_t it);
			return (widen(off[k]) <<< fbsc_pkg::FRAC_W) + widen(nx[k]) * widen(it.ax)
				+ widen(ny[k]) * widen(it.ay) + widen(nz[k]) * widen(it.az);
		endfunction

		function logic judge_visibility(cull_item_t it);
			int    cnt;
			int    first;
			logic  vis;
			wide_t lo, hi, d, r;
			cnt = (plane_count > fbsc_pkg::MAX_PLANES) ? fbsc_pkg::MAX_PLANES : plane_count;
			first = 0;
			vis = 1'b1;
			r = widen(it.scalar) <<< fbsc_pkg::FRAC_W;
			// fewer than six planes: plane 0 must be straddled
			if (cnt > 0 && cnt < fbsc_pkg::FULL_FRUSTUM) begin
				first = 1;
				if (it.kind == fbsc_pkg::KIND_BOX) begin
					box_span(0, it, lo, hi);
					if (lo > 0 || hi < 0)
						vis = 1'b0;
				end else begin
					d = centre_distance(0, it);
					if (d + r < 0 || d - r > 0)
						vis = 1'b0;
				end
			end
			for (int k = first; k < cnt; k++) begin
				if (it.kind == fbsc_pkg::KIND_BOX) begin
					box_span(k, it, lo, hi);
					if (hi < 0)
						vis = 1'b0;
				end else begin
					d = centre_distance(k, it);
					if (d + r < 0)
						vis = 1'b0;
				end
			end
			return vis;
		endfunction

		function void note_item(cull_item_t it);
			cull_answer_t ans;
			ans.visible = 1'b0;
			ans.was_test = 1'b0;
			case (it.kind)
				fbsc_pkg::KIND_LOAD: begin
					if (it.slot < fbsc_pkg::MAX_PLANES) begin
						nx[it.slot] = it.ax;
						ny[it.slot] = it.ay;
						nz[it.slot] = it.az;
						off[it.slot] = it.scalar;
					end
				end
				fbsc_pkg::KIND_BOX, fbsc_pkg::KIND_SPHERE: begin
					ans.visible = judge_visibility(it);
					ans.was_test = 1'b1;
					tests++;
					if (ans.visible)
						visibles++;
				end
				default: ;
			endcase
			pending_answers.push_back(ans);
		endfunction

		function void check_result(logic visible, logic was_test);
			cull_answer_t ans;
			if (pending_answers.size() == 0) begin
				$error("unexpected result transfer: visible %0d was_test %0d",
					visible, was_test);
				mismatches++;
				return;
			end
			ans = pending_answers.pop_front();
			if (visible !== ans.visible) begin
				$error("visible: expected %0d actual %0d", ans.visible, visible);
				mismatches++;
			end
			if (was_test !== ans.was_test) begin
				$error("was_test: expected %0d actual %0d", ans.was_test, was_test);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [231:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	cull_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;

	frustum_box_sphere_cull uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_result(m_tdata[0], m_tuser[0]);
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic cull_item_t make_item(fbsc_pkg::kind_t k, int slot,
		fbsc_pkg::q16_t ax, fbsc_pkg::q16_t ay, fbsc_pkg::q16_t az, fbsc_pkg::q16_t bx,
		fbsc_pkg::q16_t by, fbsc_pkg::q16_t bz, fbsc_pkg::q16_t scalar);
		cull_item_t it;
		it.kind = k;
		it.slot = 3'(slot);
		it.ax = ax;
		it.ay = ay;
		it.az = az;
		it.bx = bx;
		it.by = by;
		it.bz = bz;
		it.scalar = scalar;
		return it;
	endfunction

	function automatic fbsc_pkg::q16_t draw_coord();
		int             sel;
		fbsc_pkg::q16_t v;
		sel = $urandom_range(99);
		if (sel < 60) begin
			v = $urandom_range(0, 32 * 65536);
			return v - 16 * ONE;
		end
		if (sel < 85)
			return $urandom;
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -1;
			4: return ONE;
			default: return -ONE;
		endcase
	endfunction

	function automatic fbsc_pkg::q16_t draw_extent();
		int             sel;
		fbsc_pkg::q16_t v;
		sel = $urandom_range(99);
		v = $urandom_range(0, 8 * 65536);
		if (sel < 80)
			return v;
		if (sel < 90)
			return -v;
		return $urandom;
	endfunction

	// axis-aligned plane with jitter most of the time, arbitrary otherwise
	function automatic cull_item_t draw_plane(int slot);
		fbsc_pkg::q16_t n[3];
		fbsc_pkg::q16_t offs;
		int             axis;
		if ($urandom_range(99) < 60) begin
			axis = $urandom_range(2);
			foreach (n[i])
				n[i] = $signed($urandom_range(0, 8192)) - 4096;
			n[axis] = $urandom_range(1) ? ONE + n[axis] : -ONE + n[axis];
			offs = $urandom_range(0, 16 * 65536);
			offs = offs - 4 * ONE;
		end else begin
			foreach (n[i])
				n[i] = draw_coord();
			offs = draw_coord();
		end
		return make_item(fbsc_pkg::KIND_LOAD, slot, n[0], n[1], n[2], $urandom, $urandom,
			$urandom, offs);
	endfunction

	function automatic cull_item_t draw_item();
		int             sel;
		cull_item_t     it;
		fbsc_pkg::q16_t rad;
		sel = $urandom_range(99);
		if (sel < 8)
			return draw_plane($urandom_range(7));
		if (sel < 11)
			return make_item(fbsc_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		it = make_item(fbsc_pkg::kind_t'((sel < 55) ? fbsc_pkg::KIND_BOX
			: fbsc_pkg::KIND_SPHERE), $urandom, draw_coord(), draw_coord(), draw_coord(),
			0, 0, 0, 0);
		if (it.kind == fbsc_pkg::KIND_BOX) begin
			it.bx = it.ax + draw_extent();
			it.by = it.ay + draw_extent();
			it.bz = it.az + draw_extent();
			it.scalar = $urandom;
		end else begin
			sel = $urandom_range(99);
			rad = $urandom_range(0, 8 * 65536);
			it.scalar = (sel < 70) ? rad : (sel < 85) ? -rad : fbsc_pkg::q16_t'($urandom);
			it.bx = $urandom;
			it.by = $urandom;
			it.bz = $urandom;
		end
		return it;
	endfunction

	task automatic offer_item(cull_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {5'b0, it.scalar, it.bz, it.by, it.bx, it.az, it.ay, it.ax, it.slot};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// six planes bounding a cube of the given half size
	task automatic load_cube(fbsc_pkg::q16_t half, bit jitter);
		fbsc_pkg::q16_t n[3];
		for (int k = 0; k < fbsc_pkg::MAX_PLANES; k++) begin
			foreach (n[i])
				n[i] = jitter ? $signed($urandom_range(0, 4096)) - 2048 : 0;
			n[k / 2] = n[k / 2] + ((k % 2) ? -ONE : ONE);
			offer_item(make_item(fbsc_pkg::KIND_LOAD, k, n[0], n[1], n[2], $urandom,
				$urandom, $urandom, half));
		end
	endtask

	task automatic set_plane_count(logic [2:0] count);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {fbsc_pkg::REG_PLANES, 2'b00};
		pwdata <= {29'b0, count};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== {29'b0, count}) begin
			$error("planes_in_use: expected %0d actual %0d", count, prdata);
			sb.mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		sb.plane_count = count;
	endtask

	task automatic set_pacing(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 77; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 77; end
			default: begin send_idle_pct = 15; stall_pct = 15; end
		endcase
	endtask

	initial begin
		logic [2:0]     seg_counts[8];
		fbsc_pkg::q16_t mn;
		fbsc_pkg::q16_t mx;

		seg_counts = '{3'd6, 3'd1, 3'd5, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4};
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = fbsc_pkg::KIND_LOAD;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cube of half size 4 with all six planes
		load_cube(4 * ONE, 1'b0);
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, 5 * ONE, 0, 0, 6 * ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, 3 * ONE, 0, 0, 5 * ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, ONE));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, 6 * ONE, 0, 0, 0, 0, 0, ONE));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, 6 * ONE, 0, 0, 0, 0, 0, 2 * ONE));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, -5 * ONE));
		offer_item(make_item(fbsc_pkg::KIND_BOX, 7, mn, mn, mn, mx, mx, mx, mx));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 7, mx, mx, mx, mn, mn, mn, mx));
		offer_item(make_item(fbsc_pkg::KIND_NONE, 7, -1, -1, -1, -1, -1, -1, -1));
		offer_item(make_item(fbsc_pkg::KIND_LOAD, 7, mn, mx, mn, mx, mn, mx, mn));
		offer_item(make_item(fbsc_pkg::KIND_LOAD, 6, mx, mn, mx, mn, mx, mn, mx));
		drain_results();
		// straddle plane at x = -4
		set_plane_count(3'd3);
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, -5 * ONE, 0, 0, -3 * ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, -4 * ONE, 0, 0, 0, 0, 0, 0));
		drain_results();
		set_plane_count(3'd0);
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, mx, mx, mx, mx, mx, mx, 0));
		drain_results();
		set_plane_count(3'd7);
		offer_item(make_item(fbsc_pkg::KIND_BOX, 0, 9 * ONE, 0, 0, 10 * ONE, ONE, ONE, 0));
		offer_item(make_item(fbsc_pkg::KIND_SPHERE, 0, ONE, ONE, ONE, 0, 0, 0, ONE));
		drain_results();

		// random segments, cycling pacing modes and plane counts
		for (int seg = 0; seg < 8; seg++) begin
			set_plane_count(seg_counts[seg]);
			set_pacing(seg % 4);
			if (seg % 4 == 0)
				hold_requests++;
			if (seg % 3 == 2) begin
				for (int k = 0; k < fbsc_pkg::MAX_PLANES; k++)
					offer_item(draw_plane(k));
			end else begin
				load_cube($urandom_range(ONE, 12 * ONE), 1'($urandom_range(1)));
			end
			repeat (84)
				offer_item(draw_item());
			drain_results();
		end

		repeat (60) @(posedge clk);
		if (sb.pending_answers.size() != 0) begin
			$error("%0d results never arrived", sb.pending_answers.size());
			sb.mismatches++;
		end
		$display("Covered %0d transfers: %0d box/sphere tests (%0d visible), plane counts 0-7,",
			items_sent, sb.tests, sb.visibles);
		$display("  four pacing modes and long output hold-offs.");
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/fbsc_pkg.sv
rtl/fbsc_ram.sv
rtl/fbsc_dot.sv
rtl/frustum_box_sphere_cull.sv
tb/sv/tb.sv
